FILE: rtl/i2cmts_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
package i2cmts_pkg;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 32;

  // input item kinds (in_tuser)
  typedef enum logic [1:0] {
    MODE_BEGIN    = 2'd0,
    MODE_COMPLETE = 2'd1,
    MODE_TICK     = 2'd2,
    MODE_TX_BYTE  = 2'd3
  } mode_t;

  // engine commands
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_WRITE     = 3'd2;
  localparam logic [2:0] CMD_READ_ACK  = 3'd3;
  localparam logic [2:0] CMD_READ_NACK = 3'd4;
  localparam logic [2:0] CMD_STOP      = 3'd5;

  // transaction outcomes
  localparam logic [1:0] OUT_SUCCESS    = 2'd0;
  localparam logic [1:0] OUT_TIMEOUT    = 2'd1;
  localparam logic [1:0] OUT_BUS_ERROR  = 2'd2;
  localparam logic [1:0] OUT_UNEXPECTED = 2'd3;

  // engine status codes, after masking
  localparam logic [7:0] STATUS_MASK  = 8'hF8;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RESTART   = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_DATAW_ACK = 8'h28;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_READ_ACK  = 8'h50;
  localparam logic [7:0] ST_READ_NACK = 8'h58;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

  typedef enum logic [8:0] {
    PH_IDLE         = 9'b000000001,
    PH_WAIT_START   = 9'b000000010,
    PH_WAIT_SLAW    = 9'b000000100,
    PH_WANT_TX      = 9'b000001000,
    PH_WAIT_DATA    = 9'b000010000,
    PH_WAIT_RESTART = 9'b000100000,
    PH_WAIT_SLAR    = 9'b001000000,
    PH_WAIT_RACK    = 9'b010000000,
    PH_WAIT_RNACK   = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] command_byte;
    logic       need_tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic [1:0] outcome;
    logic [7:0] failing_status;
  } res_t;

endpackage

FILE: rtl/i2c_master_transfer_sequencer.sv
// Transaction sequencer that drives a byte-level I2C engine, with output skid stage.
//
// Input stream (in_*): in_tuser gives the item kind (begin, engine completion,
// millisecond tick, transmit byte); in_tdata carries the address, counts,
// engine status, received byte and transmit byte.
// Output stream (out_*): one result at most per input item: an engine command
// with its byte, a request for the next transmit byte (out_tuser[0]), a
// received byte (out_tuser[1]), and out_tlast with the outcome on the stop
// that ends a transaction.
// cfg_wr_en/cfg_wr_data set the timeout limit in ticks; write only while idle.
// Timing: an item's result is registered at the edge that takes the item, into the
// output register, or into the skid register while that one is full and stalled.
// One item per cycle is sustained while the skid register is empty: the whole
// decision is one pass of logic from the input handshake to the output register.
// Stall: a skid register holds one extra result while out_tready is low;
// in_tready drops only while the skid register is full.
// Reset: synchronous, active low: sequencer idle, counters zero, timeout
// limit 500, output and skid registers empty.
module i2c_master_transfer_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // target_addr[6:0], tx_count[22:7], rx_count[38:23], bus_status[46:39],
  // read_byte[54:47], tx_byte[62:55], zero [63]
  input  logic [i2cmts_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // command[2:0], command_byte[10:3], rx_byte[18:11], outcome[20:19],
  // failing_status[28:21], zero [31:29]
  output logic [i2cmts_pkg::OUT_DATA_W-1:0] out_tdata,
  // need_tx_byte[0], rx_valid[1]
  output logic [1:0]  out_tuser,
  // done_res
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import i2cmts_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [6:0]  target_address_r, target_address_nxt;
  logic [15:0] writes_left_r, writes_left_nxt;
  logic [15:0] reads_left_r, reads_left_nxt;
  logic [15:0] wait_ticks_r, wait_ticks_nxt;
  logic [15:0] timeout_limit_r;

  logic        out_valid_r;
  res_t        out_res_r;
  logic        skid_valid_r;
  res_t        skid_res_r;

  logic        in_fire;
  logic        out_fire;
  logic        produce;
  res_t        res;

  mode_t       mode;
  logic [6:0]  f_address;
  logic [15:0] f_tx_count;
  logic [15:0] f_rx_count;
  logic [7:0]  f_status;
  logic [7:0]  f_read_byte;
  logic [7:0]  f_tx_byte;

  logic        waiting;
  logic [7:0]  st;
  logic [7:0]  expect_st;
  logic [15:0] ticks_inc;
  logic [15:0] writes_dec;
  logic [15:0] reads_dec;

  function automatic res_t mk_cmd(input logic [2:0] cmd, input logic [7:0] byte_val);
    res_t r;
    r = '0;
    r.command      = cmd;
    r.command_byte = byte_val;
    return r;
  endfunction

  function automatic res_t mk_stop(input logic [1:0] oc, input logic [7:0] status);
    res_t r;
    r = '0;
    r.command        = CMD_STOP;
    r.done_res       = 1'b1;
    r.outcome        = oc;
    r.failing_status = status;
    return r;
  endfunction

  assign mode        = mode_t'(in_tuser);
  assign f_address   = in_tdata[6:0];
  assign f_tx_count  = in_tdata[22:7];
  assign f_rx_count  = in_tdata[38:23];
  assign f_status    = in_tdata[46:39];
  assign f_read_byte = in_tdata[54:47];
  assign f_tx_byte   = in_tdata[62:55];

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  assign waiting    = (phase_r != PH_IDLE) && (phase_r != PH_WANT_TX);
  assign st         = f_status & STATUS_MASK;
  assign ticks_inc  = (wait_ticks_r == TICKS_MAX) ? wait_ticks_r : wait_ticks_r + 16'd1;
  assign writes_dec = writes_left_r - 16'd1;
  assign reads_dec  = (reads_left_r != 16'd0) ? reads_left_r - 16'd1 : reads_left_r;

  always_comb begin
    unique case (phase_r)
      PH_WAIT_START:   expect_st = ST_START;
      PH_WAIT_SLAW:    expect_st = ST_SLAW_ACK;
      PH_WAIT_DATA:    expect_st = ST_DATAW_ACK;
      PH_WAIT_RESTART: expect_st = ST_RESTART;
      PH_WAIT_SLAR:    expect_st = ST_SLAR_ACK;
      PH_WAIT_RACK:    expect_st = ST_READ_ACK;
      default:         expect_st = ST_READ_NACK;
    endcase
  end

  always_comb begin
    phase_nxt          = phase_r;
    target_address_nxt = target_address_r;
    writes_left_nxt    = writes_left_r;
    reads_left_nxt     = reads_left_r;
    wait_ticks_nxt     = wait_ticks_r;
    produce            = 1'b0;
    res                = '0;

    if (in_fire) begin
      unique case (mode)
        MODE_BEGIN: begin
          if (phase_r == PH_IDLE) begin
            target_address_nxt = f_address;
            writes_left_nxt    = f_tx_count;
            reads_left_nxt     = f_rx_count;
            wait_ticks_nxt     = 16'd0;
            phase_nxt          = PH_WAIT_START;
            res                = mk_cmd(CMD_START, 8'd0);
            produce            = 1'b1;
          end
        end
        MODE_TICK: begin
          if (waiting) begin
            wait_ticks_nxt = ticks_inc;
            if (ticks_inc >= timeout_limit_r) begin
              res            = mk_stop(OUT_TIMEOUT, 8'd0);
              phase_nxt      = PH_IDLE;
              wait_ticks_nxt = 16'd0;
              produce        = 1'b1;
            end
          end
        end
        MODE_TX_BYTE: begin
          if (phase_r == PH_WANT_TX) begin
            res            = mk_cmd(CMD_WRITE, f_tx_byte);
            phase_nxt      = PH_WAIT_DATA;
            wait_ticks_nxt = 16'd0;
            produce        = 1'b1;
          end
        end
        default: begin
          if (waiting) begin
            produce        = 1'b1;
            wait_ticks_nxt = 16'd0;
            if (st == 8'd0) begin
              res       = mk_stop(OUT_BUS_ERROR, 8'd0);
              phase_nxt = PH_IDLE;
            end else if (st != expect_st) begin
              res       = mk_stop(OUT_UNEXPECTED, st);
              phase_nxt = PH_IDLE;
            end else begin
              unique case (phase_r)
                PH_WAIT_START: begin
                  if (writes_left_r != 16'd0) begin
                    res       = mk_cmd(CMD_WRITE, {target_address_r, 1'b0});
                    phase_nxt = PH_WAIT_SLAW;
                  end else if (reads_left_r != 16'd0) begin
                    res       = mk_cmd(CMD_WRITE, {target_address_r, 1'b1});
                    phase_nxt = PH_WAIT_SLAR;
                  end else begin
                    res       = mk_stop(OUT_SUCCESS, 8'd0);
                    phase_nxt = PH_IDLE;
                  end
                end
                PH_WAIT_SLAW: begin
                  res.need_tx_byte = 1'b1;
                  phase_nxt        = PH_WANT_TX;
                end
                PH_WAIT_DATA: begin
                  writes_left_nxt = writes_dec;
                  if (writes_dec != 16'd0) begin
                    res.need_tx_byte = 1'b1;
                    phase_nxt        = PH_WANT_TX;
                  end else if (reads_left_r != 16'd0) begin
                    // at least one byte went out here, so a repeated start follows
                    res       = mk_cmd(CMD_START, 8'd0);
                    phase_nxt = PH_WAIT_RESTART;
                  end else begin
                    res       = mk_stop(OUT_SUCCESS, 8'd0);
                    phase_nxt = PH_IDLE;
                  end
                end
                PH_WAIT_RESTART: begin
                  res       = mk_cmd(CMD_WRITE, {target_address_r, 1'b1});
                  phase_nxt = PH_WAIT_SLAR;
                end
                PH_WAIT_SLAR: begin
                  if (reads_left_r > 16'd1) begin
                    res       = mk_cmd(CMD_READ_ACK, 8'd0);
                    phase_nxt = PH_WAIT_RACK;
                  end else begin
                    res       = mk_cmd(CMD_READ_NACK, 8'd0);
                    phase_nxt = PH_WAIT_RNACK;
                  end
                end
                PH_WAIT_RACK: begin
                  reads_left_nxt = reads_dec;
                  if (reads_dec > 16'd1) begin
                    res       = mk_cmd(CMD_READ_ACK, 8'd0);
                    phase_nxt = PH_WAIT_RACK;
                  end else begin
                    res       = mk_cmd(CMD_READ_NACK, 8'd0);
                    phase_nxt = PH_WAIT_RNACK;
                  end
                  res.rx_valid = 1'b1;
                  res.rx_byte  = f_read_byte;
                end
                default: begin
                  reads_left_nxt = 16'd0;
                  res            = mk_stop(OUT_SUCCESS, 8'd0);
                  res.rx_valid   = 1'b1;
                  res.rx_byte    = f_read_byte;
                  phase_nxt      = PH_IDLE;
                end
              endcase
            end
          end
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      target_address_r <= '0;
      writes_left_r    <= '0;
      reads_left_r     <= '0;
      wait_ticks_r     <= '0;
      timeout_limit_r  <= TIMEOUT_RESET;
      out_valid_r      <= 1'b0;
      skid_valid_r     <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      target_address_r <= target_address_nxt;
      writes_left_r    <= writes_left_nxt;
      reads_left_r     <= reads_left_nxt;
      wait_ticks_r     <= wait_ticks_nxt;
      if (cfg_wr_en) begin
        timeout_limit_r <= cfg_wr_data;
      end
      if (skid_valid_r) begin
        // drain the skid register first; no input is taken meanwhile
        if (out_fire) begin
          skid_valid_r <= 1'b0;
        end
      end else if (produce) begin
        if (!out_valid_r || out_fire) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_res_r <= skid_res_r;
      end
    end else if (produce) begin
      if (!out_valid_r || out_fire) begin
        out_res_r <= res;
      end else begin
        skid_res_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_res_r.failing_status, out_res_r.outcome,
                       out_res_r.rx_byte, out_res_r.command_byte, out_res_r.command};
  assign out_tuser  = {out_res_r.rx_valid, out_res_r.need_tx_byte};
  assign out_tlast  = out_res_r.done_res;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_last_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.done_res |-> out_res_r.command == CMD_STOP)
    else $error("end of transaction without stop command");

  a_need_tx_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.need_tx_byte |-> out_res_r.command == CMD_NONE)
    else $error("transmit byte request carries an engine command");

  a_idle_ticks_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> wait_ticks_r == 16'd0)
    else $error("tick count left over in idle");

  a_stall_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !in_tready)
    else $error("input taken while skid register full");
`endif

endmodule
